[rtl/rrg_pkg.sv]
// shared types and constants for the request replay guard
`timescale 1ns / 1ps
package rrg_pkg;

  typedef enum logic [1:0] {
    CMD_CHECK      = 2'd0,
    CMD_FORGET     = 2'd1,
    CMD_FORGET_ALL = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOCLOCK = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_STALE   = 3'd3,
    ST_BADSIG  = 3'd4,
    ST_REPLAY  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } back_state_t;

  localparam int unsigned REG_MAX_SKEW = 0;
  localparam logic [31:0] MAX_SKEW_RESET = 32'd300;

  // front classification handed to the back part
  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] pre_status;
    logic       run_check;
  } front_ctl_t;

endpackage

[rtl/request_replay_guard_core.sv]
// top level of the request replay guard
// forget and early-rejected requests pass through the queue register and the result register;
// a full check also scans the tables (one entry a cycle) and then passes a done state
// the back part handles one request at a time and starts the next only once the result is taken;
// the two-entry queue takes requests while the back part works
// reset: clears queue, valid bits, ring pointer and output; max_skew returns to 300
`timescale 1ns / 1ps
module request_replay_guard_core #(
  parameter int NONCE_DEPTH = 16,
  parameter int MARK_DEPTH  = 8,
  parameter int ID_BITS     = 64,
  parameter int NONCE_BITS  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [63:0] client_id,
  input  logic [63:0] nonce_value,
  input  logic [31:0] request_time,
  input  logic [31:0] now_time,
  input  logic        clock_valid,
  input  logic        client_known,
  input  logic        signature_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [63:0] out_client_id
);

  logic [31:0]           max_skew;
  logic                  q_valid, q_pop, busy;
  rrg_pkg::front_ctl_t   q_ctl;
  logic [ID_BITS-1:0]    q_id;
  logic [NONCE_BITS-1:0] q_nonce;
  logic [31:0]           q_time;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'(rrg_pkg::REG_MAX_SKEW)) ? max_skew : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) max_skew <= rrg_pkg::MAX_SKEW_RESET;
    else if (psel && penable && pwrite && paddr == 2'(rrg_pkg::REG_MAX_SKEW))
      max_skew <= pwdata;
  end

  rrg_front #(.ID_BITS(ID_BITS), .NONCE_BITS(NONCE_BITS)) u_front (
    .clk, .rst, .max_skew, .in_valid, .in_stall, .cmd, .client_id, .nonce_value,
    .request_time, .now_time, .clock_valid, .client_known, .signature_ok,
    .q_valid, .q_pop, .q_ctl, .q_id, .q_nonce, .q_time
  );

  rrg_back #(.NONCE_DEPTH(NONCE_DEPTH), .MARK_DEPTH(MARK_DEPTH),
             .ID_BITS(ID_BITS), .NONCE_BITS(NONCE_BITS)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_ctl, .q_id, .q_nonce, .q_time,
    .out_valid, .out_stall, .status, .out_client_id, .busy
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue pop while empty");

  a_busy_holds_entry: assert property (@(posedge clk) disable iff (rst)
    busy |-> q_valid) else $error("back part busy without a queued request");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= rrg_pkg::ST_REPLAY) else $error("status out of range");

  a_id_zero_on_reject: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != rrg_pkg::ST_OK) |-> out_client_id == 64'd0)
    else $error("client id echoed on reject");

endmodule

[rtl/rrg_front.sv]
// front part: accepts requests, runs the stateless checks, fills a small queue
`timescale 1ns / 1ps
module rrg_front #(
  parameter int ID_BITS    = 64,
  parameter int NONCE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [31:0]           max_skew,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            cmd,
  input  logic [63:0]           client_id,
  input  logic [63:0]           nonce_value,
  input  logic [31:0]           request_time,
  input  logic [31:0]           now_time,
  input  logic                  clock_valid,
  input  logic                  client_known,
  input  logic                  signature_ok,
  output logic                  q_valid,
  input  logic                  q_pop,
  output rrg_pkg::front_ctl_t   q_ctl,
  output logic [ID_BITS-1:0]    q_id,
  output logic [NONCE_BITS-1:0] q_nonce,
  output logic [31:0]           q_time
);

  localparam int QD = 2;

  rrg_pkg::front_ctl_t   ctl_mem   [QD];
  logic [ID_BITS-1:0]    id_mem    [QD];
  logic [NONCE_BITS-1:0] nonce_mem [QD];
  logic [31:0]           time_mem  [QD];
  logic                  wr_ptr, rd_ptr;
  logic [1:0]            count;
  logic [31:0]           skew;
  rrg_pkg::front_ctl_t   ctl_in;
  logic                  push;

  assign skew = (now_time > request_time) ? now_time - request_time
                                          : request_time - now_time;

  always_comb begin
    ctl_in.cmd        = cmd;
    ctl_in.run_check  = 1'b0;
    ctl_in.pre_status = rrg_pkg::ST_OK;
    if (cmd == rrg_pkg::CMD_CHECK) begin
      priority if (!clock_valid) ctl_in.pre_status = rrg_pkg::ST_NOCLOCK;
      else if (!client_known)    ctl_in.pre_status = rrg_pkg::ST_UNKNOWN;
      else if (skew > max_skew)  ctl_in.pre_status = rrg_pkg::ST_STALE;
      else if (!signature_ok)    ctl_in.pre_status = rrg_pkg::ST_BADSIG;
      else                       ctl_in.run_check  = 1'b1;
    end
  end

  assign in_stall = (count == 2'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_ctl    = ctl_mem[rd_ptr];
  assign q_id     = id_mem[rd_ptr];
  assign q_nonce  = nonce_mem[rd_ptr];
  assign q_time   = time_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr]   <= ctl_in;
      id_mem[wr_ptr]    <= client_id[ID_BITS-1:0];
      nonce_mem[wr_ptr] <= nonce_value[NONCE_BITS-1:0];
      time_mem[wr_ptr]  <= request_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

[rtl/rrg_back.sv]
// back part: scans the mark table and nonce ring, updates state, holds the result
`timescale 1ns / 1ps
module rrg_back #(
  parameter int NONCE_DEPTH = 16,
  parameter int MARK_DEPTH  = 8,
  parameter int ID_BITS     = 64,
  parameter int NONCE_BITS  = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  rrg_pkg::front_ctl_t   q_ctl,
  input  logic [ID_BITS-1:0]    q_id,
  input  logic [NONCE_BITS-1:0] q_nonce,
  input  logic [31:0]           q_time,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [63:0]           out_client_id,
  output logic                  busy
);

  localparam int NW = (NONCE_DEPTH > 1) ? $clog2(NONCE_DEPTH) : 1;
  localparam int MW = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam int SL = (NONCE_DEPTH > MARK_DEPTH) ? NONCE_DEPTH : MARK_DEPTH;
  localparam int SW = $clog2(SL + 1);

  rrg_pkg::back_state_t state, state_next;

  logic [NONCE_DEPTH-1:0] nonce_valid;
  logic [ID_BITS-1:0]     nonce_client [NONCE_DEPTH];
  logic [NONCE_BITS-1:0]  nonce_stored [NONCE_DEPTH];
  logic [NW-1:0]          ring_pointer;
  logic [MARK_DEPTH-1:0]  mark_valid;
  logic [ID_BITS-1:0]     mark_client [MARK_DEPTH];
  logic [31:0]            mark_time [MARK_DEPTH];

  logic [SW-1:0] idx;
  logic          mark_hit, free_found, nonce_hit;
  logic [MW-1:0] mark_slot, free_slot;
  logic          out_full;
  logic          scan_last, start;

  assign busy      = (state != rrg_pkg::BK_IDLE);
  assign start     = q_valid && !out_full && state == rrg_pkg::BK_IDLE;
  assign scan_last = (idx == SW'(SL - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      rrg_pkg::BK_IDLE:
        if (start && q_ctl.run_check) state_next = rrg_pkg::BK_SCAN;
      rrg_pkg::BK_SCAN:
        if (scan_last) state_next = rrg_pkg::BK_DONE;
      rrg_pkg::BK_DONE: state_next = rrg_pkg::BK_IDLE;
      default: state_next = rrg_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    unique case (state)
      rrg_pkg::BK_IDLE: q_pop = start && !q_ctl.run_check;
      rrg_pkg::BK_DONE: q_pop = 1'b1;
      default:          q_pop = 1'b0;
    endcase
  end

  logic m_valid_i, n_valid_i;
  logic [MW-1:0] m_i;
  logic [NW-1:0] n_i;
  logic replay;
  logic mark_use;
  logic [MW-1:0] mslot;

  assign m_valid_i = (idx < SW'(MARK_DEPTH));
  assign n_valid_i = (idx < SW'(NONCE_DEPTH));
  assign m_i       = idx[MW-1:0];
  assign n_i       = idx[NW-1:0];
  assign mark_use  = mark_hit || free_found;
  assign mslot     = mark_hit ? mark_slot : free_slot;
  assign replay    = nonce_hit ||
                     (mark_hit && (q_time < mark_time[mark_slot]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rrg_pkg::BK_IDLE;
      out_full     <= 1'b0;
      nonce_valid  <= '0;
      mark_valid   <= '0;
      ring_pointer <= '0;
      idx          <= '0;
      mark_hit     <= 1'b0;
      free_found   <= 1'b0;
      nonce_hit    <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_full <= 1'b0;
      unique case (state)
        rrg_pkg::BK_IDLE: begin
          idx        <= '0;
          mark_hit   <= 1'b0;
          free_found <= 1'b0;
          nonce_hit  <= 1'b0;
          if (start && !q_ctl.run_check) begin
            out_full <= 1'b1;
            if (q_ctl.cmd == rrg_pkg::CMD_FORGET_ALL) begin
              nonce_valid  <= '0;
              mark_valid   <= '0;
              ring_pointer <= '0;
            end else if (q_ctl.cmd == rrg_pkg::CMD_FORGET) begin
              for (int i = 0; i < NONCE_DEPTH; i++)
                if (nonce_client[i] == q_id) nonce_valid[i] <= 1'b0;
              for (int i = 0; i < MARK_DEPTH; i++)
                if (mark_client[i] == q_id) mark_valid[i] <= 1'b0;
            end
          end
        end
        rrg_pkg::BK_SCAN: begin
          idx <= idx + SW'(1);
          if (m_valid_i) begin
            if (mark_valid[m_i] && mark_client[m_i] == q_id && !mark_hit) begin
              mark_hit  <= 1'b1;
              mark_slot <= m_i;
            end
            if (!mark_valid[m_i] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= m_i;
            end
          end
          if (n_valid_i && nonce_valid[n_i] && nonce_client[n_i] == q_id &&
              nonce_stored[n_i] == q_nonce)
            nonce_hit <= 1'b1;
        end
        rrg_pkg::BK_DONE: begin
          out_full <= 1'b1;
          if (!replay) begin
            nonce_valid[ring_pointer] <= 1'b1;
            ring_pointer <= (ring_pointer == NW'(NONCE_DEPTH - 1)) ? '0
                                                                   : ring_pointer + NW'(1);
            if (mark_use) mark_valid[mslot] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload: tables, result register
  always_ff @(posedge clk) begin
    if (state == rrg_pkg::BK_IDLE && start && !q_ctl.run_check) begin
      status        <= q_ctl.pre_status;
      out_client_id <= '0;
    end
    if (state == rrg_pkg::BK_DONE) begin
      status        <= replay ? rrg_pkg::ST_REPLAY : rrg_pkg::ST_OK;
      out_client_id <= replay ? 64'd0 : 64'(q_id);
      if (!replay) begin
        nonce_client[ring_pointer] <= q_id;
        nonce_stored[ring_pointer] <= q_nonce;
        if (mark_use) begin
          mark_client[mslot] <= q_id;
          if (!mark_hit || q_time > mark_time[mslot]) mark_time[mslot] <= q_time;
        end
      end
    end
  end

  assign out_valid = out_full;

endmodule

[dv/request_replay_guard_core_test.sv]
// testbench for request_replay_guard_core: queued requests, predicted status, checked responses
`timescale 1ns / 1ps
module request_replay_guard_core_test;

  typedef struct {
    rrg_pkg::cmd_t c;
    logic [63:0] id;
    logic [63:0] nv;
    logic [31:0] rt;
    logic [31:0] nw;
    logic        cv;
    logic        ck;
    logic        so;
  } req_t;

  typedef struct {
    rrg_pkg::status_t st;
    logic [63:0] id;
  } resp_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0, in_stall;
  logic [1:0] cmd = '0;
  logic [63:0] client_id = '0, nonce_value = '0;
  logic [31:0] request_time = '0, now_time = '0;
  logic clock_valid = 0, client_known = 0, signature_ok = 0;
  logic out_valid, out_stall = 0;
  logic [2:0] status;
  logic [63:0] out_client_id;

  request_replay_guard_core dut (.*);

  // predictor state
  logic [31:0] skew_limit;
  logic        seen_vld [16];
  logic [63:0] seen_id [16];
  logic [63:0] seen_nonce [16];
  int unsigned ring_wr;
  logic        hw_vld [8];
  logic [63:0] hw_id [8];
  logic [31:0] hw_time [8];

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int    errors = 0;
  int    cycles = 0;
  bit    quiet = 0;
  bit    hold_send = 0;
  int    send_gap = 0, recv_gap = 0;

  initial forever #4 clk = ~clk;

  function automatic void clear_tables();
    for (int i = 0; i < 16; i++) seen_vld[i] = 0;
    for (int i = 0; i < 8; i++) hw_vld[i] = 0;
    ring_wr = 0;
  endfunction

  function automatic resp_t predict_status(req_t r);
    resp_t o;
    logic [31:0] d;
    int m;
    bit hit;
    o.st = rrg_pkg::ST_OK;
    o.id = '0;
    m = -1;
    hit = 0;
    if (r.c == rrg_pkg::CMD_FORGET_ALL) begin
      clear_tables();
    end else if (r.c == rrg_pkg::CMD_FORGET) begin
      for (int i = 0; i < 16; i++) if (seen_vld[i] && seen_id[i] == r.id) seen_vld[i] = 0;
      for (int i = 0; i < 8; i++) if (hw_vld[i] && hw_id[i] == r.id) hw_vld[i] = 0;
    end else if (r.c == rrg_pkg::CMD_CHECK) begin
      d = (r.nw > r.rt) ? r.nw - r.rt : r.rt - r.nw;
      if (!r.cv) o.st = rrg_pkg::ST_NOCLOCK;
      else if (!r.ck) o.st = rrg_pkg::ST_UNKNOWN;
      else if (d > skew_limit) o.st = rrg_pkg::ST_STALE;
      else if (!r.so) o.st = rrg_pkg::ST_BADSIG;
      else begin
        for (int i = 0; i < 8; i++) if (m < 0 && hw_vld[i] && hw_id[i] == r.id) m = i;
        for (int i = 0; i < 8; i++) if (m < 0 && !hw_vld[i]) m = i;
        for (int i = 0; i < 16; i++)
          if (seen_vld[i] && seen_id[i] == r.id && seen_nonce[i] == r.nv) hit = 1;
        if (m >= 0 && hw_vld[m] && r.rt < hw_time[m]) o.st = rrg_pkg::ST_REPLAY;
        else if (hit) o.st = rrg_pkg::ST_REPLAY;
        else begin
          seen_id[ring_wr] = r.id;
          seen_nonce[ring_wr] = r.nv;
          seen_vld[ring_wr] = 1;
          ring_wr = (ring_wr + 1) % 16;
          if (m >= 0) begin
            if (!hw_vld[m] || r.rt > hw_time[m]) hw_time[m] = r.rt;
            hw_id[m] = r.id;
            hw_vld[m] = 1;
          end
          o.id = r.id;
        end
      end
    end
    return o;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_resps.push_back(predict_status(pending_reqs.pop_front()));
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 6);
          in_valid <= 0;
        end else if (pending_reqs.size() != 0 && !hold_send) begin
          in_valid <= 1;
          cmd <= pending_reqs[0].c;
          client_id <= pending_reqs[0].id;
          nonce_value <= pending_reqs[0].nv;
          request_time <= pending_reqs[0].rt;
          now_time <= pending_reqs[0].nw;
          clock_valid <= pending_reqs[0].cv;
          client_known <= pending_reqs[0].ck;
          signature_ok <= pending_reqs[0].so;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_resps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected response status=%0d id=%h", status, out_client_id);
        end else begin
          resp_t e;
          e = expected_resps.pop_front();
          if (status !== e.st || out_client_id !== e.id) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected status=%0d id=%h, got status=%0d id=%h",
                       e.st, e.id, status, out_client_id);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 6);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_skew(logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 2'(rrg_pkg::REG_MAX_SKEW); pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    skew_limit = v;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic req_t mk(rrg_pkg::cmd_t c, logic [63:0] id, logic [63:0] nv,
                              logic [31:0] rt, logic [31:0] nw, logic cv, logic ck, logic so);
    req_t r;
    r.c = c; r.id = id; r.nv = nv; r.rt = rt; r.nw = nw; r.cv = cv; r.ck = ck; r.so = so;
    return r;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_batch(int n, bit wide);
    logic [63:0] ids[6];
    logic [31:0] base;
    for (int i = 0; i < 6; i++) ids[i] = (i < 3) ? 64'(i) : rnd64();
    base = $urandom;
    for (int k = 0; k < n; k++) begin
      req_t r;
      int sel;
      sel = $urandom_range(0, 99);
      r = mk(rrg_pkg::CMD_CHECK, ids[$urandom_range(0, 5)], 64'($urandom_range(0, 7)),
             base + $urandom_range(0, 40) - 20, base, 1, 1, 1);
      if (wide) begin
        r.id = (sel < 30) ? rnd64() : ids[$urandom_range(0, 5)];
        r.nv = rnd64();
      end
      if (sel < 4) r.c = rrg_pkg::CMD_FORGET;
      else if (sel < 6) r.c = rrg_pkg::CMD_FORGET_ALL;
      else if (sel < 7) r.c = rrg_pkg::CMD_NONE;
      else if (sel < 10) r.cv = 0;
      else if (sel < 13) r.ck = 0;
      else if (sel < 16) r.so = 0;
      else if (sel < 20) r.rt = $urandom;
      else if (sel < 22) begin
        r.rt = $urandom; r.nw = $urandom;
        r.cv = 1'($urandom); r.ck = 1'($urandom); r.so = 1'($urandom);
      end
      if ($urandom_range(0, 9) == 0) base = base + $urandom_range(1, 50);
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    skew_limit = rrg_pkg::MAX_SKEW_RESET;
    clear_tables();
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: priorities, skew edge, mark and nonce replays, forget paths
    pending_reqs.push_back(mk(rrg_pkg::CMD_CHECK, '1, '1, '1, '1, 0, 0, 0));
    pending_reqs.push_back(mk(rrg_pkg::CMD_CHECK, '1, '1, '1, '1, 1, 0, 0));
    pending_reqs.push_back(mk(rrg_pkg::CMD_CHECK, 1, 1, 1000, 1300, 1, 1, 0));
    pending_reqs.push_back(mk(rrg_pkg::CMD_CHECK, 1, 1, 1000, 1301, 1, 1, 1));
    pending_reqs.push_back(mk(rrg_pkg::CMD_CHECK, 1, 1, 1300, 1000, 1, 1, 1));
    pending_reqs.push_back(mk(rrg_pkg::CMD_CHECK, 1, 1, 1300, 1000, 1, 1, 1));
    pending_reqs.push_back(mk(rrg_pkg::CMD_CHECK, 1, 2, 1299, 1000, 1, 1, 1));
    pending_reqs.push_back(mk(rrg_pkg::CMD_CHECK, '1, '1, '1, '1, 1, 1, 1));
    pending_reqs.push_back(mk(rrg_pkg::CMD_CHECK, 0, 0, 0, 0, 1, 1, 1));
    pending_reqs.push_back(mk(rrg_pkg::CMD_CHECK, 0, 0, 0, '1, 1, 1, 1));
    for (int i = 2; i < 10; i++)
      pending_reqs.push_back(mk(rrg_pkg::CMD_CHECK, i, 5, 50, 60, 1, 1, 1));
    pending_reqs.push_back(mk(rrg_pkg::CMD_CHECK, 9, 6, 10, 60, 1, 1, 1));
    pending_reqs.push_back(mk(rrg_pkg::CMD_FORGET, 1, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(rrg_pkg::CMD_CHECK, 1, 1, 1300, 1000, 1, 1, 1));
    pending_reqs.push_back(mk(rrg_pkg::CMD_NONE, 3, 3, 3, 3, 1, 1, 1));
    pending_reqs.push_back(mk(rrg_pkg::CMD_FORGET_ALL, 0, 0, 0, 0, 0, 0, 0));
    drain();

    write_skew(32'd0);
    random_batch(80, 0);
    drain();
    write_skew('1);
    random_batch(80, 1);
    // sender holds off until everything is back
    hold_send = 1;
    while (in_valid || expected_resps.size() != 0) @(posedge clk);
    hold_send = 0;
    drain();
    write_skew(32'd30);
    random_batch(200, 0);
    drain();
    write_skew(32'd5);
    quiet = 1;
    random_batch(120, 0);
    drain();

    if (errors == 0 && expected_resps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
